// ===== sv/gha_pkg.sv =====
// Shared constants, codes and control/status types for the handle allocator.
package gha_pkg;

  localparam int SLOTS    = 1024;
  localparam int GEN_BITS = 32;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MIRROR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_EXEC,
    FIN_POP,
    FIN_CLAIM
  } fin_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic rd_pop;
    logic scan_rd;
    logic scan_next;
    logic top_rd;
    logic swap_wr;
    fin_t fin;
  } gha_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             rng_err;
    logic             alive;
    logic             stack_empty;
    logic             stack_match;
    logic             scan_last;
    logic             clr_last;
    logic             out_free;
  } gha_st_t;

endpackage

// ===== sv/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gha_ctrl.sv =====
// Sequencing state machine of the handle allocator.
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gha_pkg::gha_st_t  st,
  output gha_pkg::gha_ctl_t ctl
);
  import gha_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_EXEC     = 4'd2;
  localparam logic [3:0] S_CWR      = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CMP = 4'd5;
  localparam logic [3:0] S_TOP_RD   = 4'd6;
  localparam logic [3:0] S_TOP_WR   = 4'd7;
  localparam logic [3:0] S_MFIN     = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.fin   = FIN_NONE;
    unique case (state_r)
      S_CLR: begin
        ctl.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (st.cmd == CMD_CREATE && !st.stack_empty) begin
          ctl.rd_pop = 1'b1;
          state_nxt  = S_CWR;
        end else if (st.cmd == CMD_MIRROR && !st.rng_err && !st.alive) begin
          state_nxt = st.stack_empty ? S_MFIN : S_SCAN_RD;
        end else if (st.out_free) begin
          ctl.fin   = FIN_EXEC;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_CWR: begin
        if (st.out_free) begin
          ctl.fin   = FIN_POP;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        ctl.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (st.stack_match) begin
          state_nxt = S_TOP_RD;
        end else if (st.scan_last) begin
          state_nxt = S_MFIN;
        end else begin
          ctl.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_TOP_RD: begin
        ctl.top_rd = 1'b1;
        state_nxt  = S_TOP_WR;
      end
      S_TOP_WR: begin
        ctl.swap_wr = 1'b1;
        state_nxt   = S_MFIN;
      end
      S_MFIN: begin
        if (st.out_free) begin
          ctl.fin   = FIN_CLAIM;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

// ===== sv/gha_dp.sv =====
// Datapath: slot and free-stack memories, counters and result register.
module gha_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [gha_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [gha_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gha_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [gha_pkg::STATUS_W-1:0]       out_tuser,
  input  gha_pkg::gha_ctl_t                  ctl,
  output gha_pkg::gha_st_t                   st
);
  import gha_pkg::*;

  logic [9:0]  in_idx;
  logic [31:0] in_gen;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                rng_r, rng_nxt;
  logic [GEN_BITS-1:0] gen_r, gen_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic [IDX_W-1:0]    clr_r, clr_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt;
  logic [CNT_W-1:0]    hw_r, hw_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    o_idx_r, o_idx_nxt;
  logic [GEN_BITS-1:0] o_gen_r, o_gen_nxt;
  logic                o_alive_r, o_alive_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [CNT_W-1:0]    o_live_r, o_live_nxt;

  logic                slot_we, slot_re;
  logic [IDX_W-1:0]    slot_waddr, slot_raddr;
  logic [GEN_BITS:0]   slot_wdata, slot_rdata;
  logic                stk_we, stk_re;
  logic [IDX_W-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic                sd_alive;
  logic [GEN_BITS-1:0] sd_gen;
  logic                hit;
  logic                hw_full;

  assign in_idx   = in_tdata[9:0];
  assign in_gen   = in_tdata[41:10];
  assign sd_alive = slot_rdata[GEN_BITS];
  assign sd_gen   = slot_rdata[GEN_BITS-1:0];
  assign hit      = sd_alive && (sd_gen == gen_r);
  assign hw_full  = (hw_r == CNT_W'(SLOTS));

  gha_ram #(.WIDTH(GEN_BITS + 1), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    rng_nxt       = rng_r;
    gen_nxt       = gen_r;
    slot_nxt      = slot_r;
    scan_nxt      = scan_r;
    clr_nxt       = clr_r;
    depth_nxt     = depth_r;
    hw_nxt        = hw_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_idx_nxt     = o_idx_r;
    o_gen_nxt     = o_gen_r;
    o_alive_nxt   = o_alive_r;
    o_status_nxt  = o_status_r;
    o_live_nxt    = o_live_r;
    slot_we       = 1'b0;
    slot_waddr    = idx_r;
    slot_wdata    = '0;
    slot_re       = 1'b0;
    slot_raddr    = idx_r;
    stk_we        = 1'b0;
    stk_waddr     = scan_r;
    stk_wdata     = stk_rdata;
    stk_re        = 1'b0;
    stk_raddr     = IDX_W'(depth_r - 1'b1);

    if (ctl.clr_wr) begin
      slot_we    = 1'b1;
      slot_waddr = clr_r;
      slot_wdata = '0;
      clr_nxt    = clr_r + 1'b1;
    end

    if (ctl.accept) begin
      cmd_nxt    = in_tuser;
      idx_nxt    = IDX_W'(in_idx);
      rng_nxt    = (32'(in_idx) >= 32'(SLOTS));
      gen_nxt    = in_gen[GEN_BITS-1:0];
      scan_nxt   = '0;
      slot_re    = 1'b1;
      slot_raddr = (in_tuser == CMD_CREATE) ? hw_r[IDX_W-1:0] : IDX_W'(in_idx);
      stk_re     = 1'b1;
      stk_raddr  = IDX_W'(depth_r - 1'b1);
    end

    if (ctl.rd_pop) begin
      slot_re    = 1'b1;
      slot_raddr = stk_rdata;
      slot_nxt   = stk_rdata;
    end

    if (ctl.scan_rd) begin
      stk_re    = 1'b1;
      stk_raddr = scan_r;
    end

    if (ctl.scan_next) begin
      scan_nxt = scan_r + 1'b1;
    end

    if (ctl.top_rd) begin
      stk_re    = 1'b1;
      stk_raddr = IDX_W'(depth_r - 1'b1);
    end

    if (ctl.swap_wr) begin
      stk_we    = 1'b1;
      stk_waddr = scan_r;
      stk_wdata = stk_rdata;
      depth_nxt = depth_r - 1'b1;
    end

    if (ctl.fin != FIN_NONE) begin
      out_valid_nxt = 1'b1;
      o_idx_nxt     = '0;
      o_gen_nxt     = '0;
      o_alive_nxt   = 1'b0;
      o_status_nxt  = ST_OK;
    end

    unique case (ctl.fin)
      FIN_NONE: begin
      end
      FIN_EXEC: begin
        unique case (cmd_r)
          CMD_CREATE: begin
            if (!hw_full) begin
              slot_we    = 1'b1;
              slot_waddr = hw_r[IDX_W-1:0];
              slot_wdata = {1'b1, sd_gen};
              hw_nxt     = hw_r + 1'b1;
              live_nxt   = live_r + 1'b1;
              o_idx_nxt  = hw_r[IDX_W-1:0];
              o_gen_nxt  = sd_gen;
            end else begin
              o_status_nxt = ST_FULL;
            end
          end
          CMD_DESTROY: begin
            priority if (rng_r) begin
              o_status_nxt = ST_RANGE;
            end else if (hit) begin
              slot_we    = 1'b1;
              slot_waddr = idx_r;
              slot_wdata = {1'b0, sd_gen + 1'b1};
              if (depth_r < CNT_W'(SLOTS)) begin
                stk_we    = 1'b1;
                stk_waddr = depth_r[IDX_W-1:0];
                stk_wdata = idx_r;
                depth_nxt = depth_r + 1'b1;
              end
              live_nxt = live_r - 1'b1;
            end else begin
              o_status_nxt = ST_STALE;
            end
          end
          CMD_QUERY: begin
            priority if (rng_r) begin
              o_status_nxt = ST_RANGE;
            end else if (hit) begin
              o_alive_nxt = 1'b1;
            end else begin
              o_status_nxt = ST_STALE;
            end
          end
          CMD_MIRROR: begin
            if (rng_r) begin
              o_status_nxt = ST_RANGE;
            end else begin
              if (CNT_W'(idx_r) >= hw_r) begin
                hw_nxt = CNT_W'(idx_r) + 1'b1;
              end
              if (!hit) begin
                slot_we    = 1'b1;
                slot_waddr = idx_r;
                slot_wdata = {1'b1, gen_r};
              end
              o_idx_nxt = idx_r;
              o_gen_nxt = gen_r;
            end
          end
        endcase
      end
      FIN_POP: begin
        slot_we    = 1'b1;
        slot_waddr = slot_r;
        slot_wdata = {1'b1, sd_gen};
        depth_nxt  = depth_r - 1'b1;
        live_nxt   = live_r + 1'b1;
        o_idx_nxt  = slot_r;
        o_gen_nxt  = sd_gen;
      end
      FIN_CLAIM: begin
        if (CNT_W'(idx_r) >= hw_r) begin
          hw_nxt = CNT_W'(idx_r) + 1'b1;
        end
        slot_we    = 1'b1;
        slot_waddr = idx_r;
        slot_wdata = {1'b1, gen_r};
        live_nxt   = live_r + 1'b1;
        o_idx_nxt  = idx_r;
        o_gen_nxt  = gen_r;
      end
    endcase

    if (ctl.fin != FIN_NONE) begin
      o_live_nxt = live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      hw_r        <= '0;
      live_r      <= '0;
      clr_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      hw_r        <= hw_nxt;
      live_r      <= live_nxt;
      clr_r       <= clr_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    rng_r      <= rng_nxt;
    gen_r      <= gen_nxt;
    slot_r     <= slot_nxt;
    o_idx_r    <= o_idx_nxt;
    o_gen_r    <= o_gen_nxt;
    o_alive_r  <= o_alive_nxt;
    o_status_r <= o_status_nxt;
    o_live_r   <= o_live_nxt;
  end

  assign st.cmd         = cmd_r;
  assign st.rng_err     = rng_r;
  assign st.alive       = sd_alive;
  assign st.stack_empty = (depth_r == '0);
  assign st.stack_match = (stk_rdata == idx_r);
  assign st.scan_last   = ((CNT_W'(scan_r) + 1'b1) == depth_r);
  assign st.clr_last    = (clr_r == IDX_W'(SLOTS - 1));
  assign st.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, 11'(o_live_r), o_alive_r, 32'(o_gen_r), 10'(o_idx_r)};
  assign out_tuser  = o_status_r;

`ifndef NO_ASSERTIONS
  a_live_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= hw_r)
    else $error("live count above high water");

  a_books: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, depth_r} + {1'b0, live_r}) <= {1'b0, hw_r})
    else $error("free plus live slots exceed high water");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin != FIN_NONE) |-> st.out_free)
    else $error("result written while output register busy");

  a_swap_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.swap_wr |-> (depth_r != '0))
    else $error("swap-erase on empty free stack");
`endif

endmodule

// ===== sv/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
//
// Input channel (in_*): one command per transfer. in_tuser carries the
// command (create, destroy, query, mirror claim); in_tdata carries the
// slot index and generation. Output channel (out_*): exactly one result
// per command, in order, with the status code in out_tuser.
// A create from the free stack reads the stack top, then the slot that it
// names, before the result register is written; other create, destroy,
// query and a mirror claim of a live slot write it from the execute state.
// A mirror claim of a dead slot walks the free stack one entry at a time
// through the single read port of the free-stack memory. One command is worked
// at a time and the next is taken the cycle after the result is written.
// Reset: the slot memory is cleared one entry per cycle, with in_tready
// low; then all counters are zero.
// Stall: a finished result is held in the output register; the next
// command is taken meanwhile, and its result waits until out_tready
// frees the register.
module generational_handle_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] slot_index, [41:10] slot_generation, [47:42] zero
  input  logic [gha_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [gha_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] handle_index, [41:10] handle_generation, [42] is_alive,
  // [53:43] live_total, [55:54] zero
  output logic [gha_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [gha_pkg::STATUS_W-1:0]   out_tuser
);
  import gha_pkg::*;

  gha_ctl_t ctl;
  gha_st_t  st;

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .ctl       (ctl)
  );

  gha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ctl        (ctl),
    .st         (st)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the generational handle allocator: predicted results vs. stream output.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int RANDOM_COMMANDS = 400;
  localparam int DRAIN_LIMIT     = 20000;

  typedef struct {
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
    logic                is_alive;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    live;
  } handle_result_t;

  class slot_table;
    bit                  alive[SLOTS];
    logic [GEN_BITS-1:0] gens[SLOTS];
    int                  free_stack[SLOTS];
    int                  free_depth;
    int                  high_water;
    int                  live_count;
    int                  mismatches;
    handle_result_t      expected_results[$];

    function new();
      foreach (alive[i]) begin
        alive[i] = 1'b0;
        gens[i] = '0;
        free_stack[i] = 0;
      end
      free_depth = 0;
      high_water = 0;
      live_count = 0;
      mismatches = 0;
    endfunction

    function bit is_current(int idx, logic [GEN_BITS-1:0] gen);
      return idx < high_water && alive[idx] && gens[idx] == gen;
    endfunction

    function void retire(int idx);
      alive[idx] = 1'b0;
      gens[idx] = gens[idx] + 1'b1;
      if (free_depth < SLOTS) begin
        free_stack[free_depth] = idx;
        free_depth++;
      end
      live_count--;
    endfunction

    function void unlink_free(int idx);
      bit found;
      found = 1'b0;
      for (int i = 0; i < free_depth && !found; i++) begin
        if (free_stack[i] == idx) begin
          free_stack[i] = free_stack[free_depth - 1];
          free_depth--;
          found = 1'b1;
        end
      end
    endfunction

    function void apply_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx_in,
                                logic [GEN_BITS-1:0] gen);
      handle_result_t r;
      int idx;
      int slot;
      idx = int'(idx_in);
      r.idx = '0;
      r.gen = '0;
      r.is_alive = 1'b0;
      r.status = ST_OK;
      if (cmd == CMD_CREATE) begin
        slot = -1;
        if (free_depth > 0) begin
          free_depth--;
          slot = free_stack[free_depth] % SLOTS;
        end else if (high_water < SLOTS) begin
          slot = high_water;
          high_water++;
        end
        if (slot >= 0) begin
          alive[slot] = 1'b1;
          live_count++;
          r.idx = IDX_W'(slot);
          r.gen = gens[slot];
        end else begin
          r.status = ST_FULL;
        end
      end else if (idx >= SLOTS) begin
        r.status = ST_RANGE;
      end else if (cmd == CMD_DESTROY) begin
        if (is_current(idx, gen)) retire(idx);
        else r.status = ST_STALE;
      end else if (cmd == CMD_QUERY) begin
        if (is_current(idx, gen)) r.is_alive = 1'b1;
        else r.status = ST_STALE;
      end else begin
        if (idx >= high_water) high_water = idx + 1;
        if (!(alive[idx] && gens[idx] == gen)) begin
          if (alive[idx]) retire(idx);
          unlink_free(idx);
          gens[idx] = gen;
          alive[idx] = 1'b1;
          live_count++;
        end
        r.idx = idx_in;
        r.gen = gen;
      end
      r.live = CNT_W'(live_count);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_field(string name, logic [GEN_BITS-1:0] want, logic [GEN_BITS-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
      handle_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %0h status %0h",
                 $time, data, st);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("handle_index", GEN_BITS'(want.idx), GEN_BITS'(data[9:0]));
        check_field("handle_generation", want.gen, data[41:10]);
        check_field("is_alive", GEN_BITS'(want.is_alive), GEN_BITS'(data[42]));
        check_field("live_total", GEN_BITS'(want.live), GEN_BITS'(data[53:43]));
        check_field("status", GEN_BITS'(want.status), GEN_BITS'(st));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_CREATE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  slot_table   slots = new();
  int          burst_left = 0;
  int          ready_step = 0;
  logic [15:0] ready_mask = '1;

  generational_handle_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) slots.check_result(out_tdata, out_tuser);
    if (ready_step % 64 == 0) begin
      ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
    end
    out_tready <= ready_mask[ready_step % 16];
    ready_step++;
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                       input logic [GEN_BITS-1:0] gen);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - IDX_W - GEN_BITS){1'b0}}, gen, idx};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    slots.apply_command(cmd, idx, gen);
  endtask

  task automatic wait_results_drained();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (slots.expected_results.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  function automatic int find_live_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (slots.alive[(start + k) % SLOTS]) return (start + k) % SLOTS;
    end
    return -1;
  endfunction

  task automatic send_random_command();
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
    int                  kind;
    int                  roll;
    int                  live;
    kind = $urandom_range(0, 9);
    roll = $urandom_range(0, 99);
    idx  = IDX_W'($urandom);
    gen  = $urandom;
    live = find_live_slot();
    if (kind < 3) cmd = CMD_CREATE;
    else if (kind < 5) cmd = CMD_DESTROY;
    else if (kind < 7) cmd = CMD_QUERY;
    else cmd = CMD_MIRROR;
    if (cmd == CMD_DESTROY || cmd == CMD_QUERY) begin
      if (roll < 85 && live >= 0) begin
        idx = IDX_W'(live);
        gen = (roll < 70) ? slots.gens[live] : slots.gens[live] - 1'b1;
      end
    end else if (cmd == CMD_MIRROR) begin
      if (roll < 50 && live >= 0) begin
        idx = IDX_W'(live);
        if (roll < 25) gen = slots.gens[live];
      end else if (roll < 75 && slots.free_depth > 0) begin
        idx = IDX_W'(slots.free_stack[$urandom_range(0, slots.free_depth - 1)]);
      end
      if ($urandom_range(0, 7) == 0) gen = {GEN_BITS{roll[0]}};
    end
    issue(cmd, idx, gen);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_CREATE, 10'd0, 32'h0);
    issue(CMD_CREATE, 10'd0, 32'h0);
    issue(CMD_QUERY, 10'd0, 32'h0);
    issue(CMD_QUERY, 10'd0, 32'h1);
    issue(CMD_QUERY, 10'd600, 32'h0);
    issue(CMD_DESTROY, 10'd700, 32'h0);
    issue(CMD_DESTROY, 10'd0, 32'h0);
    issue(CMD_DESTROY, 10'd0, 32'h0);
    issue(CMD_QUERY, 10'd0, 32'h0);
    issue(CMD_CREATE, 10'd0, 32'h0);
    issue(CMD_MIRROR, 10'd1, 32'h0);
    issue(CMD_MIRROR, 10'd1, 32'hFFFF_FFFF);
    issue(CMD_DESTROY, 10'd1, 32'hFFFF_FFFF);
    issue(CMD_QUERY, 10'd1, 32'h0);
    issue(CMD_MIRROR, 10'd5, 32'h5555_AAAA);
    issue(CMD_MIRROR, 10'd3, 32'h7);
    issue(CMD_MIRROR, 10'd1, 32'hAAAA_5555);
    issue(CMD_MIRROR, 10'd1023, 32'h0);
    issue(CMD_CREATE, 10'd0, 32'h0);
    issue(CMD_DESTROY, 10'd1023, 32'h0);
    issue(CMD_CREATE, 10'd0, 32'h0);
    issue(CMD_QUERY, 10'd1023, 32'h1);
    issue(CMD_QUERY, 10'd1023, 32'hFFFF_FFFF);
    wait_results_drained();

    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      send_random_command();
      if (i % 100 == 99) wait_results_drained();
    end

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (slots.expected_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, slots.expected_results.size());
      slots.mismatches++;
    end
    if (slots.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
